// ===== hdl/vtv_pkg.sv =====
// Shared types, constants and helper functions of the viewBox-to-viewport transform.
// No dependencies; every other file of the block but vtv_div imports this package.
`default_nettype none
package vtv_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ALIGN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE = 2'd1;

    localparam logic [3:0] ALIGN_NONE      = 4'd0;
    localparam logic [3:0] ALIGN_XMIN_YMIN = 4'd1;
    localparam logic [3:0] ALIGN_XMID_YMIN = 4'd2;
    localparam logic [3:0] ALIGN_XMAX_YMIN = 4'd3;
    localparam logic [3:0] ALIGN_XMIN_YMID = 4'd4;
    localparam logic [3:0] ALIGN_XMID_YMID = 4'd5;
    localparam logic [3:0] ALIGN_XMAX_YMID = 4'd6;
    localparam logic [3:0] ALIGN_XMIN_YMAX = 4'd7;
    localparam logic [3:0] ALIGN_XMID_YMAX = 4'd8;
    localparam logic [3:0] ALIGN_XMAX_YMAX = 4'd9;

    typedef enum logic [1:0] {
        WHERE_MIN = 2'd0,
        WHERE_MID = 2'd1,
        WHERE_MAX = 2'd2
    } t_where;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pw;
        logic signed [31:0] ph;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bw;
        logic signed [31:0] bh;
        logic               none;
        logic               slice;
        t_where             xw;
        t_where             yw;
        logic               bzero;
    } t_item;

    function automatic t_where where_x(input logic [3:0] mode);
        t_where w;
        unique case (mode)
            ALIGN_XMID_YMIN, ALIGN_XMID_YMID, ALIGN_XMID_YMAX: w = WHERE_MID;
            ALIGN_XMAX_YMIN, ALIGN_XMAX_YMID, ALIGN_XMAX_YMAX: w = WHERE_MAX;
            default: w = WHERE_MIN;
        endcase
        return w;
    endfunction

    function automatic t_where where_y(input logic [3:0] mode);
        t_where w;
        unique case (mode)
            ALIGN_XMIN_YMID, ALIGN_XMID_YMID, ALIGN_XMAX_YMID: w = WHERE_MID;
            ALIGN_XMIN_YMAX, ALIGN_XMID_YMAX, ALIGN_XMAX_YMAX: w = WHERE_MAX;
            default: w = WHERE_MIN;
        endcase
        return w;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? 32'(-v) : 32'(v);
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/vtv_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage, with a tag carried along.
// Uses no package.
`default_nettype none
module vtv_div #(
    parameter int NW = 48,
    parameter int DW = 32,
    parameter int TW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [TW-1:0] i_tag,
    output logic               o_valid,
    output logic [NW-1:0]      o_quo,
    output logic [TW-1:0]      o_tag
);

    for (genvar g = 0; g < NW; g++) begin : g_stage
        logic          p_v;
        logic [DW-1:0] p_rem;
        logic [NW-1:0] p_nq;
        logic [DW-1:0] p_den;
        logic [TW-1:0] p_tag;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          n_bit;
        logic          r_v;
        logic [DW-1:0] r_rem;
        logic [NW-1:0] r_nq;
        logic [DW-1:0] r_den;
        logic [TW-1:0] r_tag;

        if (g == 0) begin : g_first
            assign p_v   = i_valid;
            assign p_rem = '0;
            assign p_nq  = i_num;
            assign p_den = i_den;
            assign p_tag = i_tag;
        end else begin : g_next
            assign p_v   = g_stage[g-1].r_v;
            assign p_rem = g_stage[g-1].r_rem;
            assign p_nq  = g_stage[g-1].r_nq;
            assign p_den = g_stage[g-1].r_den;
            assign p_tag = g_stage[g-1].r_tag;
        end

        always_comb begin
            trial = {p_rem, p_nq[NW-1]};
            diff  = trial - {1'b0, p_den};
            n_bit = (trial >= {1'b0, p_den});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem <= n_bit ? diff[DW-1:0] : trial[DW-1:0];
            r_nq  <= {p_nq[NW-2:0], n_bit};
            r_den <= p_den;
            r_tag <= p_tag;
        end
    end

    assign o_valid = g_stage[NW-1].r_v;
    assign o_quo   = g_stage[NW-1].r_nq;
    assign o_tag   = g_stage[NW-1].r_tag;

endmodule
`default_nettype wire

// ===== hdl/vtv_front.sv =====
// Front part: configuration registers, command acceptance and classification of each item.
// Depends on vtv_pkg.
`default_nettype none
module vtv_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic signed [31:0]              i_port_x,
    input  wire logic signed [31:0]              i_port_y,
    input  wire logic signed [31:0]              i_port_width,
    input  wire logic signed [31:0]              i_port_height,
    input  wire logic signed [31:0]              i_box_x,
    input  wire logic signed [31:0]              i_box_y,
    input  wire logic signed [31:0]              i_box_width,
    input  wire logic signed [31:0]              i_box_height,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [vtv_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [vtv_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                                 o_push,
    output vtv_pkg::t_item                       o_item,
    input  wire logic                            i_full
);
    import vtv_pkg::*;

    logic [3:0] r_align;
    logic       r_slice;
    logic       r_valid;
    t_item      r_item;
    t_item      n_item;
    logic       accept;

    assign o_cfg_ready = 1'b1;
    assign busy        = r_valid && i_full;
    assign o_push      = r_valid && !i_full;
    assign accept      = start && !busy;
    assign o_item      = r_item;

    always_comb begin
        n_item.px    = i_port_x;
        n_item.py    = i_port_y;
        n_item.pw    = i_port_width;
        n_item.ph    = i_port_height;
        n_item.bx    = i_box_x;
        n_item.by    = i_box_y;
        n_item.bw    = i_box_width;
        n_item.bh    = i_box_height;
        n_item.none  = (r_align == ALIGN_NONE);
        n_item.slice = r_slice;
        n_item.xw    = where_x(r_align);
        n_item.yw    = where_y(r_align);
        n_item.bzero = (i_box_width == 32'sd0) || (i_box_height == 32'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align <= ALIGN_XMID_YMID;
            r_slice <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_ALIGN) begin
                r_align <= i_cfg_data[3:0];
            end else if (i_cfg_index == REG_SLICE) begin
                r_slice <= i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/vtv_queue.sv =====
// Two-entry queue of classified items between the front and the back part.
// Depends on vtv_pkg.
`default_nettype none
module vtv_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  vtv_pkg::t_item      i_item,
    input  wire logic           i_pop,
    output logic                o_valid,
    output vtv_pkg::t_item      o_item,
    output logic                o_full
);
    import vtv_pkg::*;

    t_item      r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       do_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_item  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (do_pop) begin
                r_rd <= !r_rd;
            end
            r_count <= r_count + 2'(i_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
        end else begin
            assert (!(i_push && o_full && !do_pop))
                else $error("push into full queue");
        end
    end

    property p_count_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_count != 2'd3;
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("queue count out of range");

    property p_no_overflow;
        @(posedge i_clk) disable iff (!i_rst_n) o_full && !do_pop |-> !i_push;
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("push into full queue");

    property p_count_step;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_push && !do_pop |=> r_count == $past(r_count) + 2'd1;
    endproperty
    a_count_step: assert property (p_count_step) else $error("queue count did not advance");

endmodule
`default_nettype wire

// ===== hdl/vtv_back.sv =====
// Back part: scale division, meet/slice choice, alignment division and offset arithmetic.
// Depends on vtv_pkg and vtv_div.
`default_nettype none
module vtv_back #(
    parameter int FRAC_BITS = vtv_pkg::FRAC_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  vtv_pkg::t_item     i_item,
    output logic               o_valid,
    output logic signed [31:0] o_scale_x,
    output logic signed [31:0] o_scale_y,
    output logic signed [31:0] o_offset_x,
    output logic signed [31:0] o_offset_y,
    output logic               o_degenerate
);
    import vtv_pkg::*;

    localparam int NW = 32 + FRAC_BITS;
    localparam int SW = NW + 2;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] T_LIM = 64'sd4294967295;

    typedef struct packed {
        t_item              it;
        logic signed [31:0] scx;
        logic signed [31:0] scy;
        logic signed [31:0] s;
        logic               degen;
        logic               negx;
    } t_mid;

    // Scale division.
    logic          a_vx;
    logic [NW-1:0] a_qx;
    logic [NW-1:0] a_qy;
    logic [$bits(t_item):0] a_tag;
    logic          a_negy;
    logic          a_vy;

    vtv_div #(.NW(NW), .DW(32), .TW($bits(t_item) + 1)) u_div_ax (
        .i_clk, .i_rst_n,
        .i_valid (i_valid),
        .i_num   ({mag32(i_item.pw), {FRAC_BITS{1'b0}}}),
        .i_den   ((i_item.bw == 32'sd0) ? 32'd1 : mag32(i_item.bw)),
        .i_tag   ({i_item, i_item.pw[31] ^ i_item.bw[31]}),
        .o_valid (a_vx),
        .o_quo   (a_qx),
        .o_tag   (a_tag)
    );

    vtv_div #(.NW(NW), .DW(32), .TW(1)) u_div_ay (
        .i_clk, .i_rst_n,
        .i_valid (i_valid),
        .i_num   ({mag32(i_item.ph), {FRAC_BITS{1'b0}}}),
        .i_den   ((i_item.bh == 32'sd0) ? 32'd1 : mag32(i_item.bh)),
        .i_tag   (i_item.ph[31] ^ i_item.bh[31]),
        .o_valid (a_vy),
        .o_quo   (a_qy),
        .o_tag   (a_negy)
    );

    // Stage 1: signed, saturated axis scales.
    logic               r_s1_v;
    t_item              r_s1_it;
    logic signed [31:0] r_s1_scx, r_s1_scy;
    logic               r_s1_degen;
    logic signed [31:0] n_s1_scx, n_s1_scy;
    logic signed [NW:0] a_sx, a_sy;

    always_comb begin
        a_sx = a_tag[0] ? -$signed({1'b0, a_qx}) : $signed({1'b0, a_qx});
        a_sy = a_negy   ? -$signed({1'b0, a_qy}) : $signed({1'b0, a_qy});
        n_s1_scx = sat32(64'(a_sx));
        n_s1_scy = sat32(64'(a_sy));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= a_vx && a_vy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_it    <= t_item'(a_tag[$bits(t_item):1]);
        r_s1_scx   <= n_s1_scx;
        r_s1_scy   <= n_s1_scy;
        r_s1_degen <= a_tag[1] || (n_s1_scx == 32'sd0) || (n_s1_scy == 32'sd0);
    end

    // Stage 2: meet or slice.
    logic               r_s2_v;
    t_mid               r_s2;
    logic signed [31:0] n_s2_s;

    always_comb begin
        if (r_s1_it.slice) begin
            n_s2_s = (r_s1_scx > r_s1_scy) ? r_s1_scx : r_s1_scy;
        end else begin
            n_s2_s = (r_s1_scx < r_s1_scy) ? r_s1_scx : r_s1_scy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2.it    <= r_s1_it;
        r_s2.scx   <= r_s1_scx;
        r_s2.scy   <= r_s1_scy;
        r_s2.s     <= n_s2_s;
        r_s2.degen <= r_s1_degen;
        r_s2.negx  <= r_s1_it.pw[31] ^ n_s2_s[31];
    end

    // Visible size division for the aligned modes.
    logic             b_vx, b_vy;
    logic [NW-1:0]    b_qx, b_qy;
    logic [$bits(t_mid)-1:0] b_tag;
    logic             b_negy;
    t_mid             b_m;

    vtv_div #(.NW(NW), .DW(32), .TW($bits(t_mid))) u_div_bx (
        .i_clk, .i_rst_n,
        .i_valid (r_s2_v),
        .i_num   ({mag32(r_s2.it.pw), {FRAC_BITS{1'b0}}}),
        .i_den   ((r_s2.s == 32'sd0) ? 32'd1 : mag32(r_s2.s)),
        .i_tag   (r_s2),
        .o_valid (b_vx),
        .o_quo   (b_qx),
        .o_tag   (b_tag)
    );

    vtv_div #(.NW(NW), .DW(32), .TW(1)) u_div_by (
        .i_clk, .i_rst_n,
        .i_valid (r_s2_v),
        .i_num   ({mag32(r_s2.it.ph), {FRAC_BITS{1'b0}}}),
        .i_den   ((r_s2.s == 32'sd0) ? 32'd1 : mag32(r_s2.s)),
        .i_tag   (r_s2.it.ph[31] ^ r_s2.s[31]),
        .o_valid (b_vy),
        .o_quo   (b_qy),
        .o_tag   (b_negy)
    );

    assign b_m = t_mid'(b_tag);

    // Stage 3: alignment shifts.
    logic               r_s3_v;
    t_mid               r_s3;
    logic signed [SW-1:0] r_s3_shx, r_s3_shy;
    logic signed [NW:0] b_wx, b_wy;
    logic signed [63:0] b_spx, b_spy, n_shx, n_shy;

    always_comb begin
        b_wx  = b_m.negx ? -$signed({1'b0, b_qx}) : $signed({1'b0, b_qx});
        b_wy  = b_negy   ? -$signed({1'b0, b_qy}) : $signed({1'b0, b_qy});
        b_spx = 64'(b_m.it.bw) - 64'(b_wx);
        b_spy = 64'(b_m.it.bh) - 64'(b_wy);
        n_shx = 64'sd0;
        n_shy = 64'sd0;
        if (!b_m.it.none) begin
            unique case (b_m.it.xw)
                WHERE_MID: n_shx = b_spx >>> 1;
                WHERE_MAX: n_shx = b_spx;
                default:   n_shx = 64'sd0;
            endcase
            unique case (b_m.it.yw)
                WHERE_MID: n_shy = b_spy >>> 1;
                WHERE_MAX: n_shy = b_spy;
                default:   n_shy = 64'sd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= b_vx && b_vy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3     <= b_m;
        r_s3_shx <= n_shx[SW-1:0];
        r_s3_shy <= n_shy[SW-1:0];
    end

    // Stage 4: clamped translations and per-axis scale.
    logic               r_s4_v;
    logic signed [33:0] r_s4_tx, r_s4_ty;
    logic signed [31:0] r_s4_mx, r_s4_my, r_s4_px, r_s4_py;
    logic               r_s4_degen, r_s4_none;
    logic signed [63:0] c_tx, c_ty, n_tx, n_ty;

    always_comb begin
        c_tx = -64'(r_s3.it.bx) - 64'(r_s3_shx);
        c_ty = -64'(r_s3.it.by) - 64'(r_s3_shy);
        n_tx = (c_tx > T_LIM) ? T_LIM : ((c_tx < -T_LIM) ? -T_LIM : c_tx);
        n_ty = (c_ty > T_LIM) ? T_LIM : ((c_ty < -T_LIM) ? -T_LIM : c_ty);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else begin
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_tx    <= n_tx[33:0];
        r_s4_ty    <= n_ty[33:0];
        r_s4_mx    <= r_s3.it.none ? r_s3.scx : r_s3.s;
        r_s4_my    <= r_s3.it.none ? r_s3.scy : r_s3.s;
        r_s4_px    <= r_s3.it.px;
        r_s4_py    <= r_s3.it.py;
        r_s4_degen <= r_s3.degen;
        r_s4_none  <= r_s3.it.none;
    end

    // Stage 5: products.
    logic               r_s5_v;
    logic signed [65:0] r_s5_prx, r_s5_pry;
    logic signed [31:0] r_s5_mx, r_s5_my, r_s5_px, r_s5_py;
    logic               r_s5_degen, r_s5_none;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else begin
            r_s5_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_prx   <= r_s4_mx * r_s4_tx;
        r_s5_pry   <= r_s4_my * r_s4_ty;
        r_s5_mx    <= r_s4_mx;
        r_s5_my    <= r_s4_my;
        r_s5_px    <= r_s4_px;
        r_s5_py    <= r_s4_py;
        r_s5_degen <= r_s4_degen;
        r_s5_none  <= r_s4_none;
    end

    // Stage 6: offsets and result registers.
    logic               r_v;
    logic signed [31:0] r_sx, r_sy, r_ox, r_oy;
    logic               r_degen, r_none;
    logic signed [65:0] c_flx, c_fly;

    always_comb begin
        c_flx = r_s5_prx >>> FRAC_BITS;
        c_fly = r_s5_pry >>> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_degen <= r_s5_degen;
        r_none  <= r_s5_none;
        if (r_s5_degen) begin
            r_sx <= ONE;
            r_sy <= ONE;
            r_ox <= r_s5_px;
            r_oy <= r_s5_py;
        end else begin
            r_sx <= r_s5_mx;
            r_sy <= r_s5_my;
            r_ox <= sat32(64'(r_s5_px) + c_flx[63:0]);
            r_oy <= sat32(64'(r_s5_py) + c_fly[63:0]);
        end
    end

    assign o_valid      = r_v;
    assign o_scale_x    = r_sx;
    assign o_scale_y    = r_sy;
    assign o_offset_x   = r_ox;
    assign o_offset_y   = r_oy;
    assign o_degenerate = r_degen;

    property p_degen_unit;
        @(posedge i_clk) disable iff (!i_rst_n)
            o_valid && o_degenerate |-> o_scale_x == ONE && o_scale_y == ONE;
    endproperty
    a_degen_unit: assert property (p_degen_unit) else $error("degenerate result lost unit scale");

    property p_scale_nonzero;
        @(posedge i_clk) disable iff (!i_rst_n)
            o_valid && !o_degenerate |-> o_scale_x != 32'sd0 && o_scale_y != 32'sd0;
    endproperty
    a_scale_nonzero: assert property (p_scale_nonzero) else $error("zero scale not flagged");

    property p_uniform;
        @(posedge i_clk) disable iff (!i_rst_n)
            o_valid && !o_degenerate && !r_none |-> o_scale_x == o_scale_y;
    endproperty
    a_uniform: assert property (p_uniform) else $error("aligned mode gave unequal scales");

endmodule
`default_nettype wire

// ===== hdl/viewbox_to_viewport_transform.sv =====
// Top level of the viewBox-to-viewport transform block.
// Depends on vtv_pkg, vtv_front, vtv_queue and vtv_back.
//
// Usage:
//   Command channel: an item (viewport and viewBox rectangles, Q16.16 by
//   default) is taken at a rising edge with start high and busy low.
//   Configuration channel: i_cfg_valid with i_cfg_index and i_cfg_data writes
//   align_mode (index 0) or slice_mode (index 1); o_cfg_ready is always high.
//   Write configuration only while no item is in flight.
//   Result channel: o_valid is high for one cycle per item with the scale,
//   offset and degenerate fields; the receiver must take it in that cycle.
//   Throughput is one item per clock. An accepted item passes the front
//   register, the queue, the scale dividers, the meet/slice choice, the
//   visible-size dividers and the offset arithmetic before o_valid rises;
//   all dividers are pipelined restoring ones, one quotient bit per stage.
//   A short queue sits between the front and the back part; since the back
//   part never stalls, busy stays low in normal operation.
//   Reset clears all pipeline valid bits and loads align_mode to xMidYMid
//   and slice_mode to meet.
`default_nettype none
module viewbox_to_viewport_transform #(
    parameter int FRAC_BITS = vtv_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic signed [31:0]              i_port_x,
    input  wire logic signed [31:0]              i_port_y,
    input  wire logic signed [31:0]              i_port_width,
    input  wire logic signed [31:0]              i_port_height,
    input  wire logic signed [31:0]              i_box_x,
    input  wire logic signed [31:0]              i_box_y,
    input  wire logic signed [31:0]              i_box_width,
    input  wire logic signed [31:0]              i_box_height,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [vtv_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [vtv_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                                 o_valid,
    output logic signed [31:0]                   o_scale_x,
    output logic signed [31:0]                   o_scale_y,
    output logic signed [31:0]                   o_offset_x,
    output logic signed [31:0]                   o_offset_y,
    output logic                                 o_degenerate
);
    import vtv_pkg::*;

    logic  push;
    logic  full;
    logic  q_valid;
    t_item f_item;
    t_item q_item;

    vtv_front u_front (
        .i_clk, .i_rst_n,
        .start, .busy,
        .i_port_x, .i_port_y, .i_port_width, .i_port_height,
        .i_box_x, .i_box_y, .i_box_width, .i_box_height,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_push (push),
        .o_item (f_item),
        .i_full (full)
    );

    vtv_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (1'b1),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_full  (full)
    );

    vtv_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid      (q_valid),
        .i_item       (q_item),
        .o_valid,
        .o_scale_x,
        .o_scale_y,
        .o_offset_x,
        .o_offset_y,
        .o_degenerate
    );

endmodule
`default_nettype wire

// ===== verif/viewbox_to_viewport_transform_tb.sv =====
// Testbench of the viewBox-to-viewport transform: drives rectangle pairs and register writes,
// predicts every result in fixed point and compares each one as it comes.
// Depends on vtv_pkg and viewbox_to_viewport_transform.
`default_nettype none
module viewbox_to_viewport_transform_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vtv_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int LATENCY = 2 * (32 + FB) + 8;
    localparam longint ONE_Q = 64'sd1 << FB;
    localparam longint T_LIM = 64'sd4294967295;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic               degen;
    } t_transform;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] px = '0, py = '0, pw = '0, ph = '0;
    logic signed [31:0] bx = '0, by = '0, bw = '0, bh = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic o_valid, o_degenerate;
    logic signed [31:0] o_scale_x, o_scale_y, o_offset_x, o_offset_y;

    logic [3:0] align_q;
    logic slice_q;
    t_transform expected_transforms[$];
    int errors = 0;
    int results_seen = 0;
    int items_sent = 0;
    int send_idle_pct = 0;
    longint cycles = 0;

    always #6 i_clk = ~i_clk;

    viewbox_to_viewport_transform i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_port_x(px), .i_port_y(py), .i_port_width(pw), .i_port_height(ph),
        .i_box_x(bx), .i_box_y(by), .i_box_width(bw), .i_box_height(bh),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_valid(o_valid), .o_scale_x(o_scale_x), .o_scale_y(o_scale_y),
        .o_offset_x(o_offset_x), .o_offset_y(o_offset_y), .o_degenerate(o_degenerate)
    );

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint sat_word(longint v);
        return clamp_to(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic longint div_floor(longint v, longint d);
        longint q;
        q = v / d;
        if ((v % d) != 0 && v < 0) q -= 1;
        return q;
    endfunction

    function automatic longint place_origin(longint origin, longint s, longint t);
        longint tc;
        tc = clamp_to(t, -T_LIM, T_LIM);
        return sat_word(origin + div_floor(s * tc, ONE_Q));
    endfunction

    function automatic longint align_shift(longint bsz, longint psz, longint s, int where);
        longint spare;
        spare = bsz - (psz * ONE_Q) / s;
        if (where == 1) return div_floor(spare, 2);
        if (where == 2) return spare;
        return 0;
    endfunction

    function automatic t_transform fit_viewbox(longint ix, longint iy, longint iw,
                                               longint ih, longint jx, longint jy,
                                               longint jw, longint jh);
        t_transform r;
        longint scx, scy, s, sx, sy, ox, oy;
        int xw, yw;
        sx = ONE_Q; sy = ONE_Q; ox = ix; oy = iy;
        r.degen = 1'b1;
        if (jw != 0 && jh != 0) begin
            scx = sat_word((iw * ONE_Q) / jw);
            scy = sat_word((ih * ONE_Q) / jh);
            if (scx != 0 && scy != 0) begin
                r.degen = 1'b0;
                if (align_q == ALIGN_NONE) begin
                    sx = scx; sy = scy;
                    ox = place_origin(ix, scx, -jx);
                    oy = place_origin(iy, scy, -jy);
                end else begin
                    if (slice_q) s = (scx > scy) ? scx : scy;
                    else s = (scx < scy) ? scx : scy;
                    xw = 0; yw = 0;
                    if (align_q <= ALIGN_XMAX_YMAX) begin
                        xw = (align_q - 1) % 3;
                        yw = (align_q - 1) / 3;
                    end
                    sx = s; sy = s;
                    ox = place_origin(ix, s, -jx - align_shift(jw, iw, s, xw));
                    oy = place_origin(iy, s, -jy - align_shift(jh, ih, s, yw));
                end
            end
        end
        r.sx = sx[31:0]; r.sy = sy[31:0]; r.ox = ox[31:0]; r.oy = oy[31:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_transform e;
        if (i_rst_n && o_valid) begin
            results_seen <= results_seen + 1;
            if (expected_transforms.size() == 0) begin
                $display("%0t unexpected result", $time);
                errors <= errors + 1;
            end else begin
                e = expected_transforms.pop_front();
                if (o_scale_x !== e.sx || o_scale_y !== e.sy || o_offset_x !== e.ox ||
                    o_offset_y !== e.oy || o_degenerate !== e.degen) begin
                    $display("%0t mismatch exp sx=%h sy=%h ox=%h oy=%h dg=%b", $time,
                             e.sx, e.sy, e.ox, e.oy, e.degen);
                    $display("%0t          got sx=%h sy=%h ox=%h oy=%h dg=%b", $time,
                             o_scale_x, o_scale_y, o_offset_x, o_offset_y, o_degenerate);
                    errors <= errors + 1;
                end
            end
        end
    end

    task automatic send_rects(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d,
                              logic [31:0] e, logic [31:0] f, logic [31:0] g,
                              logic [31:0] h);
        logic was_busy;
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        px <= a; py <= b; pw <= c; ph <= d; bx <= e; by <= f; bw <= g; bh <= h;
        expected_transforms.push_back(fit_viewbox($signed(a), $signed(b), $signed(c),
            $signed(d), $signed(e), $signed(f), $signed(g), $signed(h)));
        items_sent++;
        do begin
            @(negedge i_clk);
            was_busy = busy;
            @(posedge i_clk);
        end while (was_busy);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (expected_transforms.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [3:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        if (idx == REG_ALIGN) align_q = value;
        else slice_q = value[0];
    endtask

    task automatic set_mode(logic [3:0] al, logic sl);
        drain();
        write_reg(REG_ALIGN, al);
        write_reg(REG_SLICE, {3'b0, sl});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(32'h0030_0000, 32'h0001_0000);
            2: return -$urandom_range(32'h0030_0000, 32'h0000_0100);
            3: return $urandom_range(32'h7FFF_FFFF, 32'h7FF0_0000);
            4: return 32'h8000_0000 + $urandom_range(255);
            default: return $urandom_range(32'h0100_0000, 0);
        endcase
    endfunction

    task automatic test_directed;
        logic [31:0] mx, mn;
        mx = 32'h7FFF_FFFF; mn = 32'h8000_0000;
        send_rects(0, 0, 32'h0064_0000, 32'h0032_0000, 0, 0, 32'h000A_0000, 32'h000A_0000);
        send_rects(5, 6, 32'h0064_0000, 32'h0032_0000, 1, 2, 0, 32'h000A_0000);
        send_rects(5, 6, 32'h0064_0000, 32'h0032_0000, 1, 2, 32'h000A_0000, 0);
        send_rects(7, 8, 1, 32'h0001_0000, 0, 0, mx, 32'h0001_0000);
        send_rects(mx, mn, mx, mx, mn, mx, 1, 1);
        send_rects(mn, mx, mn, mn, mx, mn, 1, mn);
        send_rects(0, 0, 32'hFFF0_0000, 32'h0020_0000, 32'h0010_0000, 0,
                   32'h0004_0000, 32'hFFFC_0000);
        send_rects(mx, mx, mx, mx, mx, mx, mx, mx);
        send_rects(mn, mn, mn, mn, mn, mn, mn, mn);
        send_rects(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_align_modes;
        for (int m = 0; m < 16; m++) begin
            set_mode(m[3:0], m[0]);
            for (int k = 0; k < 3; k++)
                send_rects(rand_word(), rand_word(), 32'h00C8_0000, 32'h0064_0000,
                           rand_word(), rand_word(), 32'h0032_0000 + m, 32'h0046_0000);
        end
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) set_mode(4'($urandom_range(15)), 1'($urandom_range(1)));
            send_rects(rand_word(), rand_word(), rand_word(), rand_word(),
                       rand_word(), rand_word(), rand_word(), rand_word());
        end
    endtask

    initial begin
        align_q = ALIGN_XMID_YMID;
        slice_q = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        set_mode(ALIGN_NONE, 1'b1);
        test_directed();
        test_align_modes();
        send_idle_pct = 9;
        test_random(130);
        send_idle_pct = 59;
        test_random(130);
        send_idle_pct = 0;
        test_random(140);
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Sent %0d rectangle pairs, checked %0d results over all alignment,",
                 items_sent, results_seen);
        $display("meet/slice, degenerate and saturating cases.");
        if (errors == 0 && expected_transforms.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
